@@ rtl/core/rtcda_pkg.sv @@
// Types, constants and helper functions for the RTC snapshot decoder.
// It stands alone and is imported by rtc_datetime_decode_alarm.
package rtcda_pkg;

   localparam logic [16:0] OffsetMax    = 17'd86400;
   localparam logic [7:0]  CenturyBit   = 8'h80;
   localparam logic [7:0]  MonthMask    = 8'h7F;
   localparam logic [7:0]  YearLimit    = 8'd199;
   localparam logic [7:0]  CenturyYears = 8'd100;
   localparam logic [5:0]  SecsPerMin   = 6'd60;
   localparam logic [4:0]  HoursPerDay  = 5'd24;
   localparam logic [7:0]  MaxHour      = 8'd23;
   localparam logic [7:0]  MaxMinSec    = 8'd59;
   localparam logic [7:0]  MonthFeb     = 8'd2;
   localparam logic [7:0]  MonthDec     = 8'd12;

   // Reciprocal factors for exact quotients over the value ranges used here.
   localparam logic [17:0] Recip60Wide  = 18'd139811;
   localparam int          Shift60Wide  = 23;
   localparam logic [11:0] Recip60Narrow = 12'd2185;
   localparam int          Shift60Narrow = 17;
   localparam logic [9:0]  Recip24      = 10'd683;
   localparam int          Shift24      = 14;
   localparam logic [7:0]  Recip10      = 8'd205;
   localparam int          Shift10      = 11;

   localparam int NumStages = 8;

   localparam logic [4:0] MonthLen [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef struct packed {
      logic [7:0]  sec_bcd;
      logic [7:0]  min_bcd;
      logic [7:0]  hour_bcd;
      logic [7:0]  date_bcd;
      logic [7:0]  month_bcd;
      logic [7:0]  year_bcd;
      logic [7:0]  status_byte;
      logic [16:0] offset_seconds;
   } req_type;

   typedef struct packed {
      logic       time_valid;
      logic [7:0] second_bin;
      logic [7:0] minute_bin;
      logic [7:0] hour_bin;
      logic [7:0] day_bin;
      logic [7:0] month_bin;
      logic [7:0] year_bin;
      logic [7:0] status_out;
      logic [7:0] alarm_second;
      logic [7:0] alarm_minute;
      logic [7:0] alarm_hour;
      logic [7:0] alarm_day;
   } rsp_type;

   typedef struct packed {
      logic [7:0] sec;
      logic [7:0] minute;
      logic [7:0] hour;
      logic [7:0] day;
      logic [7:0] month;
      logic [7:0] year;
      logic [7:0] status;
      logic [4:0] days_in_month;
      logic       time_valid;
   } dec_type;

   function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
      logic [7:0] six_tens;
      six_tens = {3'b000, v[7:4], 1'b0} + {2'b00, v[7:4], 2'b00};
      return v - six_tens;
   endfunction

   function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
      logic [15:0] prod;
      logic [4:0]  tens;
      prod = {8'd0, v} * {8'd0, Recip10};
      tens = prod[Shift10 +: 5];
      return v + {2'b00, tens, 1'b0} + {1'b0, tens, 2'b00};
   endfunction

   function automatic logic [4:0] month_days(input logic [7:0] month);
      logic [4:0] len;
      if (month >= 8'd1 && month <= MonthDec) begin
         len = MonthLen[4'(month - 8'd1)];
      end else begin
         len = 5'd31;
      end
      return len;
   endfunction

endpackage

@@ rtl/core/rtc_datetime_decode_alarm.sv @@
// Top level of the RTC snapshot decoder with alarm offset.
// Depends on rtcda_pkg for the payload types, constants and BCD helpers.
//
// The block decodes one RTC register snapshot per clock cycle while the result side accepts, and
// returns one result per snapshot, in order. Its register stages are decode, validity check with
// the first reciprocal product (seconds carry), seconds remainder, second product (minutes
// carry), minutes remainder, third product (hours carry), hours remainder with day wrap, and
// BCD encode. The pipeline advances as a whole whenever the output register is empty or its
// transfer completes, so a stall on the result side holds every stage in place and the next
// input is taken in the same cycle that the pending result leaves.
module rtc_datetime_decode_alarm (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rtcda_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rtcda_pkg::rsp_type rsp_data
);
   import rtcda_pkg::*;

   logic                 en;
   logic [NumStages-1:0] vld_ff;
   dec_type              dec_ff [NumStages-1];

   dec_type     dec1_in;
   logic [16:0] dt_sat;
   logic [16:0] t0_in, t0_ff, t0_2_ff;
   dec_type     dec2_in;
   logic        leap;
   logic [4:0]  dim_base;
   logic [4:0]  feb_len;
   logic        ok;
   logic [34:0] p0_in, p0_ff;
   logic [10:0] q0;
   logic [16:0] q0x60;
   logic [5:0]  r0_in, r0_3_ff, r0_4_ff, r0_5_ff, r0_6_ff, r0_7_ff;
   logic [10:0] t1_in, t1_3_ff, t1_4_ff;
   logic [22:0] p1_in, p1_ff;
   logic [5:0]  q1;
   logic [10:0] q1x60;
   logic [5:0]  r1_in, r1_5_ff, r1_6_ff, r1_7_ff;
   logic [8:0]  t2_in, t2_5_ff, t2_6_ff;
   logic [18:0] p2_in, p2_ff;
   logic [4:0]  q2;
   logic [8:0]  q2x24;
   logic [4:0]  r2_in, r2_7_ff;
   logic [7:0]  aday_sum;
   logic [7:0]  aday_in, aday_7_ff;
   rsp_type     rsp_in, rsp_ff;

   assign en        = !vld_ff[NumStages-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[NumStages-1];
   assign rsp_data  = rsp_ff;

   // Stage 1: BCD decode, century fold-in, offset saturation.
   always_comb begin
      dec1_in               = '0;
      dec1_in.sec           = bcd_to_bin(req_data.sec_bcd);
      dec1_in.minute        = bcd_to_bin(req_data.min_bcd);
      dec1_in.hour          = bcd_to_bin(req_data.hour_bcd);
      dec1_in.day           = bcd_to_bin(req_data.date_bcd);
      dec1_in.month         = bcd_to_bin(req_data.month_bcd & MonthMask);
      dec1_in.year          = bcd_to_bin(req_data.year_bcd)
                            + (((req_data.month_bcd & CenturyBit) != 8'd0) ?
                               CenturyYears : 8'd0);
      dec1_in.status        = req_data.status_byte;
      dt_sat = (req_data.offset_seconds > OffsetMax) ? OffsetMax : req_data.offset_seconds;
      t0_in  = dt_sat + {9'd0, dec1_in.sec};
   end

   // Stage 2: validity check and first reciprocal product.
   always_comb begin
      leap     = (dec_ff[0].year[1:0] == 2'b00) && (dec_ff[0].year != CenturyYears);
      dim_base = month_days(dec_ff[0].month);
      feb_len  = (dec_ff[0].month == MonthFeb && leap) ? dim_base + 5'd1 : dim_base;
      ok       = (dec_ff[0].year <= YearLimit)
              && (dec_ff[0].month >= 8'd1) && (dec_ff[0].month <= MonthDec)
              && (dec_ff[0].day != 8'd0)
              && (dec_ff[0].hour <= MaxHour)
              && (dec_ff[0].minute <= MaxMinSec)
              && (dec_ff[0].sec <= MaxMinSec)
              && (dec_ff[0].day <= {3'b000, feb_len});
      dec2_in               = dec_ff[0];
      dec2_in.time_valid    = ok;
      dec2_in.days_in_month = dim_base;
      p0_in = {18'd0, t0_ff} * {17'd0, Recip60Wide};
   end

   // Stage 3: seconds remainder and minutes carry.
   always_comb begin
      q0    = p0_ff[Shift60Wide +: 11];
      q0x60 = {q0, 6'd0} - {4'd0, q0, 2'd0};
      r0_in = 6'(t0_2_ff - q0x60);
      t1_in = q0 + {3'd0, dec_ff[1].minute};
   end

   // Stage 4: second reciprocal product.
   assign p1_in = {12'd0, t1_3_ff} * {11'd0, Recip60Narrow};

   // Stage 5: minutes remainder and hours carry.
   always_comb begin
      q1    = p1_ff[Shift60Narrow +: 6];
      q1x60 = {q1, 5'd0} - {3'd0, q1, 2'd0} + {q1, 5'd0};
      r1_in = 6'(t1_4_ff - q1x60);
      t2_in = {3'd0, q1} + {1'b0, dec_ff[3].hour};
   end

   // Stage 6: third reciprocal product.
   assign p2_in = {10'd0, t2_5_ff} * {9'd0, Recip24};

   // Stage 7: hours remainder and one month wrap of the day.
   always_comb begin
      q2       = p2_ff[Shift24 +: 5];
      q2x24    = {1'b0, q2, 3'd0} + {q2, 4'd0};
      r2_in    = 5'(t2_6_ff - q2x24);
      aday_sum = {3'd0, q2} + dec_ff[5].day;
      if (aday_sum > {3'd0, dec_ff[5].days_in_month}) begin
         aday_in = aday_sum - {3'd0, dec_ff[5].days_in_month};
      end else begin
         aday_in = aday_sum;
      end
   end

   // Stage 8: BCD encode into the output register.
   always_comb begin
      rsp_in.time_valid   = dec_ff[6].time_valid;
      rsp_in.second_bin   = dec_ff[6].sec;
      rsp_in.minute_bin   = dec_ff[6].minute;
      rsp_in.hour_bin     = dec_ff[6].hour;
      rsp_in.day_bin      = dec_ff[6].day;
      rsp_in.month_bin    = dec_ff[6].month;
      rsp_in.year_bin     = dec_ff[6].year;
      rsp_in.status_out   = dec_ff[6].status;
      rsp_in.alarm_second = bin_to_bcd({2'd0, r0_7_ff});
      rsp_in.alarm_minute = bin_to_bcd({2'd0, r1_7_ff});
      rsp_in.alarm_hour   = bin_to_bcd({3'd0, r2_7_ff});
      rsp_in.alarm_day    = bin_to_bcd(aday_7_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NumStages-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dec_ff[0] <= dec1_in;
         dec_ff[1] <= dec2_in;
         for (int i = 2; i < NumStages - 1; i++) begin
            dec_ff[i] <= dec_ff[i-1];
         end
         t0_ff     <= t0_in;
         t0_2_ff   <= t0_ff;
         p0_ff     <= p0_in;
         r0_3_ff   <= r0_in;
         t1_3_ff   <= t1_in;
         r0_4_ff   <= r0_3_ff;
         t1_4_ff   <= t1_3_ff;
         p1_ff     <= p1_in;
         r0_5_ff   <= r0_4_ff;
         r1_5_ff   <= r1_in;
         t2_5_ff   <= t2_in;
         r0_6_ff   <= r0_5_ff;
         r1_6_ff   <= r1_5_ff;
         t2_6_ff   <= t2_5_ff;
         p2_ff     <= p2_in;
         r0_7_ff   <= r0_6_ff;
         r1_7_ff   <= r1_6_ff;
         r2_7_ff   <= r2_in;
         aday_7_ff <= aday_in;
         rsp_ff    <= rsp_in;
      end
   end

   // A stalled pipeline keeps every occupied stage in place.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline occupancy changed during a stall");

   // Every transfer taken at the input occupies the first stage next cycle.
   a_take_in: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("input transfer was not captured");

   // The alarm time is always a legal BCD time of day.
   a_alarm_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.alarm_second <= 8'h59 && rsp_data.alarm_second[3:0] <= 4'd9
                  && rsp_data.alarm_minute <= 8'h59 && rsp_data.alarm_minute[3:0] <= 4'd9
                  && rsp_data.alarm_hour <= 8'h23 && rsp_data.alarm_hour[3:0] <= 4'd9))
      else $error("alarm time out of range");

   // A valid flag implies the decoded time of day, day and month are in range.
   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.time_valid) |-> (rsp_data.second_bin <= MaxMinSec
         && rsp_data.minute_bin <= MaxMinSec && rsp_data.hour_bin <= MaxHour
         && rsp_data.day_bin != 8'd0 && rsp_data.month_bin <= MonthDec))
      else $error("valid flag set on an out-of-range time");

endmodule

@@ bench/rtcda_tb_pkg.sv @@
// Checking side of the RTC snapshot decoder bench: BCD helpers and a ledger class.
// The ledger predicts each decode and matches results in order of transfer.
// Depends on rtcda_pkg for the payload types and the calendar constants.
`timescale 1ns / 1ps

package rtcda_tb_pkg;
   import rtcda_pkg::*;

   function automatic logic [7:0] from_bcd(input logic [7:0] v);
      logic [7:0] tens;
      tens = {4'd0, v[7:4]};
      return v - tens * 8'd6;
   endfunction

   function automatic logic [7:0] to_bcd(input logic [7:0] v);
      logic [7:0] tens;
      tens = v / 8'd10;
      return v + tens * 8'd6;
   endfunction

   function automatic int unsigned month_length(input logic [7:0] m);
      case (m)
         8'd4, 8'd6, 8'd9, 8'd11: return 30;
         8'd2: return 28;
         default: return 31;
      endcase
   endfunction

   class decode_ledger;
      rsp_type awaited_decodes[$];
      int unsigned mismatches = 0;

      function rsp_type decode_snapshot(input req_type s);
         rsp_type r;
         int unsigned carry;
         int unsigned span;
         int unsigned feb_limit;
         logic [7:0] part;
         logic [7:0] day_sum;
         r.second_bin = from_bcd(s.sec_bcd);
         r.minute_bin = from_bcd(s.min_bcd);
         r.hour_bin = from_bcd(s.hour_bcd);
         r.day_bin = from_bcd(s.date_bcd);
         r.month_bin = from_bcd(s.month_bcd & MonthMask);
         r.year_bin = from_bcd(s.year_bcd);
         if (s.month_bcd[7]) begin
            r.year_bin = r.year_bin + CenturyYears;
         end
         r.status_out = s.status_byte;

         carry = 32'((s.offset_seconds > OffsetMax) ? OffsetMax : s.offset_seconds);
         carry = carry + 32'(r.second_bin);
         part = 8'(carry % 60);
         r.alarm_second = to_bcd(part);
         carry = carry / 60 + 32'(r.minute_bin);
         part = 8'(carry % 60);
         r.alarm_minute = to_bcd(part);
         carry = carry / 60 + 32'(r.hour_bin);
         part = 8'(carry % 24);
         r.alarm_hour = to_bcd(part);
         day_sum = 8'(carry / 24 + 32'(r.day_bin));
         span = month_length(r.month_bin);
         if (32'(day_sum) > span) begin
            day_sum = day_sum - 8'(span);
         end
         r.alarm_day = to_bcd(day_sum);

         feb_limit = span;
         if (r.month_bin == 8'd2 && r.year_bin != CenturyYears && r.year_bin[1:0] == 2'b00) begin
            feb_limit = span + 1;
         end
         r.time_valid = (r.year_bin <= YearLimit) && (r.month_bin >= 8'd1) &&
                        (r.month_bin <= 8'd12) && (r.day_bin != 8'd0) &&
                        (r.hour_bin <= 8'd23) && (r.minute_bin <= 8'd59) &&
                        (r.second_bin <= 8'd59) && (32'(r.day_bin) <= feb_limit);
         return r;
      endfunction

      function void note_snapshot(input req_type s);
         awaited_decodes.push_back(decode_snapshot(s));
      endfunction

      function void compare_field(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_decode(input rsp_type got);
         rsp_type want;
         if (awaited_decodes.size() == 0) begin
            $error("result transfer with no snapshot awaiting it");
            mismatches++;
         end else begin
            want = awaited_decodes.pop_front();
            compare_field("time_valid", {7'd0, want.time_valid}, {7'd0, got.time_valid});
            compare_field("second_bin", want.second_bin, got.second_bin);
            compare_field("minute_bin", want.minute_bin, got.minute_bin);
            compare_field("hour_bin", want.hour_bin, got.hour_bin);
            compare_field("day_bin", want.day_bin, got.day_bin);
            compare_field("month_bin", want.month_bin, got.month_bin);
            compare_field("year_bin", want.year_bin, got.year_bin);
            compare_field("status_out", want.status_out, got.status_out);
            compare_field("alarm_second", want.alarm_second, got.alarm_second);
            compare_field("alarm_minute", want.alarm_minute, got.alarm_minute);
            compare_field("alarm_hour", want.alarm_hour, got.alarm_hour);
            compare_field("alarm_day", want.alarm_day, got.alarm_day);
         end
      endfunction

      function int unsigned outstanding();
         return awaited_decodes.size();
      endfunction
   endclass

endpackage

@@ bench/tb_rtc_datetime_decode_alarm.sv @@
// Top of the RTC snapshot decoder bench: clock, reset, snapshot and result drivers.
// Directed calendar corner cases come first, then random snapshots; random stalls run until a calm tail.
// Depends on rtcda_pkg and rtcda_tb_pkg.
`timescale 1ns / 1ps

module tb_rtc_datetime_decode_alarm;
   import rtcda_pkg::*;
   import rtcda_tb_pkg::*;

   localparam int unsigned RandomSnapshots = 2000;
   localparam int unsigned CalmTail = 300;
   localparam int unsigned IdleLimit = 2000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b1;
   rsp_type rsp_data;
   bit      calm = 1'b0;

   decode_ledger ledger = new();

   rtc_datetime_decode_alarm i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic req_type snap(input logic [7:0] sec, input logic [7:0] minute,
                                    input logic [7:0] hour, input logic [7:0] date,
                                    input logic [7:0] month, input logic [7:0] year,
                                    input logic [7:0] status, input logic [16:0] offset);
      req_type s;
      s.sec_bcd = sec;
      s.min_bcd = minute;
      s.hour_bcd = hour;
      s.date_bcd = date;
      s.month_bcd = month;
      s.year_bcd = year;
      s.status_byte = status;
      s.offset_seconds = offset;
      return s;
   endfunction

   task automatic send_snapshot(input req_type s);
      req_valid <= 1'b1;
      req_data <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic await_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.outstanding() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            ledger.note_snapshot(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            ledger.check_decode(rsp_data);
         end
      end
   end

   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      req_type s;
      logic [7:0] mon;
      bit well_formed;
      int unsigned pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 17'd0));
      send_snapshot(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 17'h1FFFF));
      send_snapshot(snap(8'h59, 8'h59, 8'h23, 8'h29, 8'h02, 8'h24, 8'hA5, 17'd1));
      send_snapshot(snap(8'h00, 8'h00, 8'h12, 8'h29, 8'h82, 8'h00, 8'h5A, 17'd0));
      send_snapshot(snap(8'h00, 8'h00, 8'h12, 8'h29, 8'h02, 8'h00, 8'h00, 17'd100));
      send_snapshot(snap(8'h30, 8'h45, 8'h10, 8'h29, 8'h02, 8'h23, 8'h01, 17'd3600));
      send_snapshot(snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h80, 17'd86400));
      send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h0F, 17'd86401));
      send_snapshot(snap(8'h15, 8'h30, 8'h06, 8'h10, 8'h13, 8'h10, 8'hF0, 17'd50000));
      send_snapshot(snap(8'h15, 8'h30, 8'h06, 8'h10, 8'h00, 8'h10, 8'h33, 17'd7000));
      send_snapshot(snap(8'h5A, 8'h7B, 8'h3C, 8'h2D, 8'h1E, 8'h0F, 8'hC3, 17'd12345));
      send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h15, 8'h86, 8'h99, 8'h11, 17'd0));
      send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h15, 8'h86, 8'hA0, 8'h22, 17'd0));
      send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h21, 8'h44, 17'd60));
      send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h31, 8'h04, 8'h21, 8'h55, 17'd0));
      send_snapshot(snap(8'h00, 8'h00, 8'h24, 8'h01, 8'h01, 8'h21, 8'h66, 17'd0));
      send_snapshot(snap(8'h00, 8'h60, 8'h00, 8'h01, 8'h01, 8'h21, 8'h77, 17'd0));
      send_snapshot(snap(8'h60, 8'h00, 8'h00, 8'h01, 8'h01, 8'h21, 8'h88, 17'd0));
      send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h30, 8'h04, 8'h21, 8'h99, 17'd86399));
      send_snapshot(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h8C, 8'hFF, 8'hAA, 17'd86400));
      send_snapshot(snap(8'h59, 8'h59, 8'h23, 8'h28, 8'h02, 8'h22, 8'hBB, 17'd65536));
      send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h04, 8'hCC, 17'h0AAAA));
      send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h29, 8'h82, 8'h04, 8'hDD, 17'h15555));
      await_drain();

      for (int unsigned i = 0; i < RandomSnapshots; i++) begin
         if (i == RandomSnapshots / 2) begin
            await_drain();
         end
         if (i == RandomSnapshots - CalmTail) begin
            calm = 1'b1;
         end
         well_formed = ($urandom_range(0, 9) < 7);
         if (well_formed) begin
            mon = 8'($urandom_range(1, 12));
            s.sec_bcd = to_bcd(8'($urandom_range(0, 59)));
            s.min_bcd = to_bcd(8'($urandom_range(0, 59)));
            s.hour_bcd = to_bcd(8'($urandom_range(0, 23)));
            s.date_bcd = to_bcd(8'($urandom_range(1, month_length(mon)
                                                   + ((mon == 8'd2) ? 1 : 0))));
            s.month_bcd = to_bcd(mon) | ($urandom_range(0, 1) ? CenturyBit : 8'h00);
            s.year_bcd = to_bcd(8'($urandom_range(0, 99)));
         end else begin
            s.sec_bcd = 8'($urandom);
            s.min_bcd = 8'($urandom);
            s.hour_bcd = 8'($urandom);
            s.date_bcd = 8'($urandom);
            s.month_bcd = 8'($urandom);
            s.year_bcd = 8'($urandom);
         end
         s.status_byte = 8'($urandom);
         pick = $urandom_range(0, 9);
         case (pick)
            6: s.offset_seconds = 17'($urandom_range(86401, 131071));
            7: s.offset_seconds = 17'($urandom_range(86340, 86400));
            8: s.offset_seconds = 17'($urandom_range(0, 120));
            9: s.offset_seconds = 17'($urandom);
            default: s.offset_seconds = 17'($urandom_range(0, 86400));
         endcase
         send_snapshot(s);
      end

      await_drain();
      repeat (16) @(posedge clock);
      if (ledger.outstanding() == 0 && ledger.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
